// ===== rtl/pas_pkg.sv =====
// Shared types and constants of the 3D shoelace polygon area block.
`timescale 1ns / 1ps

package pas_pkg;

   // Field widths.
   localparam int COORD_W = 16;
   localparam int NORM_W = 16;
   localparam int COUNT_W = 9;
   localparam int AREA_W = 55;

   // Vertex count saturates at this value.
   localparam int MAX_VERTICES = 256;

   // Internal arithmetic widths.
   localparam int CROSS_W = 2 * COORD_W + 1;
   localparam int PROD_W = CROSS_W + NORM_W;
   localparam int EDGE_W = PROD_W + 2;
   localparam int SUM_W = 58;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result queue.
   localparam int OUT_DEPTH = 4;
   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vec_type;

   // One unit of work for the back part: the edge from prev_pt to cur_pt when
   // has_edge is set, and the closing edge from cur_pt to first_pt when last is set.
   typedef struct packed {
      vec_type              prev_pt;
      vec_type              cur_pt;
      vec_type              first_pt;
      vec_type              normal;
      logic                 has_edge;
      logic                 last;
      logic                 clear;
      logic [COUNT_W-1:0]   count;
   } entry_type;

endpackage

// ===== rtl/pas_front.sv =====
// Front part: takes vertex items, tracks polygon state and queues edge work.
`timescale 1ns / 1ps

module pas_front import pas_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [COORD_W-1:0] req_vertex_x,
   input  logic signed [COORD_W-1:0] req_vertex_y,
   input  logic signed [COORD_W-1:0] req_vertex_z,
   input  logic signed [NORM_W-1:0]  req_normal_x,
   input  logic signed [NORM_W-1:0]  req_normal_y,
   input  logic signed [NORM_W-1:0]  req_normal_z,
   input  logic                      req_last_vertex,
   output logic                      q_push,
   output entry_type                 q_data,
   input  logic                      q_full
);

   logic               accept;
   logic               in_poly_ff, in_poly_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   vec_type            first_ff, first_in;
   vec_type            prev_ff;
   vec_type            normal_ff, normal_in;
   vec_type            cur_pt;
   vec_type            req_normal;

   assign req_full = q_full;
   assign accept = req_push && !q_full;

   assign cur_pt = '{x: req_vertex_x, y: req_vertex_y, z: req_vertex_z};
   assign req_normal = '{x: req_normal_x, y: req_normal_y, z: req_normal_z};

   // Polygon bookkeeping: the first item latches the first point and the normal.
   always_comb begin
      in_poly_in = in_poly_ff;
      count_in = count_ff;
      first_in = first_ff;
      normal_in = normal_ff;
      if (accept) begin
         if (!in_poly_ff) begin
            first_in = cur_pt;
            normal_in = req_normal;
            count_in = COUNT_W'(1);
         end else if (count_ff < COUNT_W'(MAX_VERTICES)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         in_poly_in = !req_last_vertex;
      end
   end

   // Every item but an opening vertex that does not also close gives work.
   always_comb begin
      q_push = accept && (in_poly_ff || req_last_vertex);
      q_data.prev_pt = prev_ff;
      q_data.cur_pt = cur_pt;
      q_data.first_pt = in_poly_ff ? first_ff : cur_pt;
      q_data.normal = in_poly_ff ? normal_ff : req_normal;
      q_data.has_edge = in_poly_ff;
      q_data.last = req_last_vertex;
      q_data.clear = !in_poly_ff || (count_ff == COUNT_W'(1));
      q_data.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_poly_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         in_poly_ff <= in_poly_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      normal_ff <= normal_in;
      if (accept) begin
         prev_ff <= cur_pt;
      end
   end

endmodule

// ===== rtl/pas_edge_queue.sv =====
// Short queue of edge work between the front and back parts.
`timescale 1ns / 1ps

module pas_edge_queue import pas_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      valid
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop = pop && valid;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally at the power-of-two depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pas_back.sv =====
// Back part: cross products, normal weighting, saturating sum and result queue.
`timescale 1ns / 1ps

module pas_back import pas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  entry_type          q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [AREA_W-1:0]  rsp_area,
   output logic [COUNT_W-1:0] rsp_vertex_count
);

   // Cross-product component issued in a cycle, and which edge of the item.
   localparam logic [1:0] COMP_Z = 2'd0;
   localparam logic [1:0] COMP_X = 2'd1;
   localparam logic [1:0] COMP_Y = 2'd2;
   localparam logic EDGE_OPEN = 1'b0;
   localparam logic EDGE_CLOSE = 1'b1;

   localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic               first_of_edge;
      logic               last_of_edge;
      logic               clear;
      logic               finish;
      logic [COUNT_W-1:0] count;
   } uop_ctl_type;

   typedef struct packed {
      logic [AREA_W-1:0]  area;
      logic [COUNT_W-1:0] count;
   } result_type;

   // Issue sequencer.
   logic        busy_ff, busy_in;
   logic        edge_ff, edge_in;
   logic [1:0]  comp_ff, comp_in;
   entry_type   work_ff;
   logic        uop_finish, room, stall, issue, entry_done, load;
   vec_type     pa, pb;
   logic signed [COORD_W-1:0] m0a, m0b, m1a, m1b;
   logic signed [NORM_W-1:0]  nsel;
   logic signed [2*COORD_W-1:0] prod0, prod1;
   logic signed [CROSS_W-1:0]   cross_in;
   uop_ctl_type uop_ctl;

   // Datapath stages.
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_fin_ff;
   logic signed [CROSS_W-1:0] s1_cross_ff;
   logic signed [NORM_W-1:0]  s1_norm_ff;
   uop_ctl_type               s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic signed [PROD_W-1:0]  s2_prod_ff;
   logic signed [EDGE_W-1:0]  s3_edge_ff;
   logic signed [SUM_W-1:0]   sum_ff, sum_in, sum_base;
   logic signed [SUM_W:0]     sum_wide;
   logic [COUNT_W-1:0]        s4_count_ff;

   // Result formation and queue.
   logic [SUM_W-1:0]     mag;
   logic [SUM_W-2:0]     half;
   result_type           res_in;
   result_type           out_slot_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]    out_wr_ptr_ff, out_rd_ptr_ff;
   logic [OCNT_W-1:0]    out_count_ff;
   logic [OCNT_W-1:0]    inflight_ff;
   logic                 out_wr, out_rd;
   logic [OCNT_W:0]      reserved;

   // Edge operands and the component selected this cycle.
   always_comb begin
      pa = (edge_ff == EDGE_CLOSE) ? work_ff.cur_pt : work_ff.prev_pt;
      pb = (edge_ff == EDGE_CLOSE) ? work_ff.first_pt : work_ff.cur_pt;
      case (comp_ff)
         COMP_Z: begin
            m0a = pa.x; m0b = pb.y; m1a = pa.y; m1b = pb.x; nsel = work_ff.normal.z;
         end
         COMP_X: begin
            m0a = pa.y; m0b = pb.z; m1a = pa.z; m1b = pb.y; nsel = work_ff.normal.x;
         end
         default: begin
            m0a = pa.z; m0b = pb.x; m1a = pa.x; m1b = pb.z; nsel = work_ff.normal.y;
         end
      endcase
      prod0 = m0a * m0b;
      prod1 = m1a * m1b;
      cross_in = {prod0[2*COORD_W-1], prod0} - {prod1[2*COORD_W-1], prod1};
   end

   // A closing component may issue only when its result has a reserved slot.
   assign reserved = {1'b0, out_count_ff} + {1'b0, inflight_ff};
   assign room = (reserved < (OCNT_W+1)'(OUT_DEPTH));
   assign uop_finish = work_ff.last && (edge_ff == EDGE_CLOSE) && (comp_ff == COMP_Y);
   assign stall = uop_finish && !room;
   assign issue = busy_ff && !stall;
   assign entry_done = issue && (comp_ff == COMP_Y)
                       && ((edge_ff == EDGE_CLOSE) || !work_ff.last);
   assign load = (!busy_ff || entry_done) && q_valid;
   assign q_pop = load;

   always_comb begin
      uop_ctl.first_of_edge = (comp_ff == COMP_Z);
      uop_ctl.last_of_edge = (comp_ff == COMP_Y);
      uop_ctl.clear = work_ff.clear && ((edge_ff == EDGE_OPEN) || !work_ff.has_edge);
      uop_ctl.finish = uop_finish;
      uop_ctl.count = work_ff.count;
   end

   // Sequencer: three components per edge, open edge before closing edge.
   always_comb begin
      busy_in = busy_ff;
      edge_in = edge_ff;
      comp_in = comp_ff;
      if (load) begin
         busy_in = 1'b1;
         edge_in = q_data.has_edge ? EDGE_OPEN : EDGE_CLOSE;
         comp_in = COMP_Z;
      end else if (entry_done) begin
         busy_in = 1'b0;
      end else if (issue) begin
         if (comp_ff == COMP_Y) begin
            comp_in = COMP_Z;
            edge_in = EDGE_CLOSE;
         end else begin
            comp_in = comp_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         edge_ff <= EDGE_OPEN;
         comp_ff <= COMP_Z;
      end else begin
         busy_ff <= busy_in;
         edge_ff <= edge_in;
         comp_ff <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         work_ff <= q_data;
      end
   end

   // Stage valids and the finish path.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_fin_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_ctl_ff.last_of_edge;
         s4_fin_ff <= s3_valid_ff && s3_ctl_ff.finish;
      end
   end

   // Cross component, then weighting by the normal, then the edge total.
   always_ff @(posedge clock) begin
      s1_cross_ff <= cross_in;
      s1_norm_ff <= nsel;
      s1_ctl_ff <= uop_ctl;
      s2_prod_ff <= s1_cross_ff * s1_norm_ff;
      s2_ctl_ff <= s1_ctl_ff;
      if (s2_valid_ff) begin
         if (s2_ctl_ff.first_of_edge) begin
            s3_edge_ff <= EDGE_W'(s2_prod_ff);
         end else begin
            s3_edge_ff <= s3_edge_ff + EDGE_W'(s2_prod_ff);
         end
         s3_ctl_ff <= s2_ctl_ff;
      end
      if (s3_valid_ff) begin
         s4_count_ff <= s3_ctl_ff.count;
      end
   end

   // Running sum with saturation after each edge; a new polygon starts from zero.
   always_comb begin
      sum_base = s3_ctl_ff.clear ? '0 : sum_ff;
      sum_wide = {sum_base[SUM_W-1], sum_base} + (SUM_W+1)'(s3_edge_ff);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? SUM_LO : SUM_HI;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (s3_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   // Area is half the magnitude, saturated; fewer than three vertices give zero.
   always_comb begin
      mag = sum_ff[SUM_W-1] ? (SUM_W)'(-sum_ff) : sum_ff;
      half = mag[SUM_W-1:1];
      if (s4_count_ff <= COUNT_W'(2)) begin
         res_in.area = '0;
      end else if (|half[SUM_W-2:AREA_W]) begin
         res_in.area = '1;
      end else begin
         res_in.area = half[AREA_W-1:0];
      end
      res_in.count = s4_count_ff;
   end

   // Result queue with credits for closing items still in the datapath.
   assign out_wr = s4_fin_ff;
   assign rsp_empty = (out_count_ff == '0);
   assign out_rd = rsp_pop && !rsp_empty;
   assign rsp_area = out_slot_ff[out_rd_ptr_ff].area;
   assign rsp_vertex_count = out_slot_ff[out_rd_ptr_ff].count;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff <= '0;
         inflight_ff <= '0;
      end else begin
         if (out_wr) begin
            out_wr_ptr_ff <= out_wr_ptr_ff + OPTR_W'(1);
         end
         if (out_rd) begin
            out_rd_ptr_ff <= out_rd_ptr_ff + OPTR_W'(1);
         end
         if (out_wr && !out_rd) begin
            out_count_ff <= out_count_ff + OCNT_W'(1);
         end else if (out_rd && !out_wr) begin
            out_count_ff <= out_count_ff - OCNT_W'(1);
         end
         if ((issue && uop_finish) && !out_wr) begin
            inflight_ff <= inflight_ff + OCNT_W'(1);
         end else if (out_wr && !(issue && uop_finish)) begin
            inflight_ff <= inflight_ff - OCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_wr) begin
         out_slot_ff[out_wr_ptr_ff] <= res_in;
      end
   end

`ifndef SYNTHESIS
   // Credits never exceed the result queue's depth.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      reserved <= (OCNT_W+1)'(OUT_DEPTH))
      else $error("result credits exceed queue depth");

   // A finished result always holds a credit taken at issue.
   a_finish_has_credit: assert property (@(posedge clock) disable iff (reset)
      s4_fin_ff |-> (inflight_ff != '0))
      else $error("result written without a credit");

   // Work is taken from the edge queue only when it holds an item.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("edge queue popped while empty");
`endif

endmodule

// ===== rtl/polygon_area_3d_shoelace.sv =====
// Throughput: the front takes an item each cycle while the two-entry edge queue has room;
// the back part issues three cross-product components per middle vertex and six on a
// closing vertex that is not the first, using the shared pair of 16x16 multipliers that forms
// one cross-product component per cycle unless a closing item stalls for a result slot.
// Reset: synchronous, active high; it empties both queues and awaits a polygon's first vertex.
`timescale 1ns / 1ps

module polygon_area_3d_shoelace import pas_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic signed [COORD_W-1:0] req_vertex_x,
   input  logic signed [COORD_W-1:0] req_vertex_y,
   input  logic signed [COORD_W-1:0] req_vertex_z,
   input  logic signed [NORM_W-1:0]  req_normal_x,
   input  logic signed [NORM_W-1:0]  req_normal_y,
   input  logic signed [NORM_W-1:0]  req_normal_z,
   input  logic                      req_last_vertex,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [AREA_W-1:0]        rsp_area,
   output logic [COUNT_W-1:0]       rsp_vertex_count
);

   logic      q_push, q_full, q_pop, q_valid;
   entry_type q_push_data, q_pop_data;

   // Front part: polygon tracking and edge work generation.
   pas_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_vertex_z    (req_vertex_z),
      .req_normal_x    (req_normal_x),
      .req_normal_y    (req_normal_y),
      .req_normal_z    (req_normal_z),
      .req_last_vertex (req_last_vertex),
      .q_push          (q_push),
      .q_data          (q_push_data),
      .q_full          (q_full)
   );

   // Decoupling queue.
   pas_edge_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .valid     (q_valid)
   );

   // Back part: arithmetic and results.
   pas_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_pop_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_area         (rsp_area),
      .rsp_vertex_count (rsp_vertex_count)
   );

endmodule
